// ===== design/ptd_pkg.sv =====
// ----------------------------------------------------------------------------
// ptd_pkg: shared types for the periodic task dispatcher
// Command, status and result-kind codes, the slot record kept in memory,
// the controller state encoding and the fixed payload widths.
// ----------------------------------------------------------------------------
`default_nettype none

package ptd_pkg;

  // Fixed payload widths
  localparam int unsigned CmdW    = 3;
  localparam int unsigned TaskW   = 8;
  localparam int unsigned PeriodW = 32;
  localparam int unsigned SlotW   = 3;
  localparam int unsigned StatusW = 2;

  typedef enum logic [CmdW-1:0] {
    CMD_TICK        = 3'd0,
    CMD_SUBSCRIBE   = 3'd1,
    CMD_UNSUBSCRIBE = 3'd2,
    CMD_INIT        = 3'd3,
    CMD_DESTROY     = 3'd4
  } cmd_e;

  typedef enum logic [StatusW-1:0] {
    STS_SUCCESS  = 2'd0,
    STS_FAIL     = 2'd1,
    STS_NO_INIT  = 2'd2,
    STS_NO_TASKS = 2'd3
  } status_e;

  typedef enum logic {
    KIND_FIRE   = 1'b0,
    KIND_STATUS = 1'b1
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_SCAN   = 3'b010,
    S_STATUS = 3'b100
  } state_e;

  // One slot record as held in the slot memory
  typedef struct packed {
    logic [TaskW-1:0]   task_id;
    logic [PeriodW-1:0] period;
    logic [PeriodW-1:0] stamp;
  } slot_entry_t;

  localparam int unsigned EntryW = $bits(slot_entry_t);

endpackage

`default_nettype wire

// ===== design/ptd_if.sv =====
// ----------------------------------------------------------------------------
// ptd_if: request and response channels of the periodic task dispatcher
// Valid/ready channels; a request is moved when valid and ready are both
// high at a rising clock edge.
// ----------------------------------------------------------------------------
`default_nettype none

interface ptd_req_if;
  logic                          valid;
  logic                          ready;
  logic [ptd_pkg::CmdW-1:0]      command;
  logic [ptd_pkg::TaskW-1:0]     task_id;
  logic [ptd_pkg::PeriodW-1:0]   period;

  modport source (output valid, command, task_id, period, input ready);
  modport sink   (input valid, command, task_id, period, output ready);
endinterface

interface ptd_rsp_if;
  logic                          valid;
  logic                          ready;
  logic                          kind;
  logic [ptd_pkg::SlotW-1:0]     slot;
  logic [ptd_pkg::TaskW-1:0]     fired_task;
  logic [ptd_pkg::StatusW-1:0]   status;
  logic                          last;

  modport source (output valid, kind, slot, fired_task, status, last, input ready);
  modport sink   (input valid, kind, slot, fired_task, status, last, output ready);
endinterface

`default_nettype wire

// ===== design/periodic_task_dispatcher.sv =====
// Timing: subscribe, init, destroy, undefined codes, and a tick or unsubscribe
// while disabled or with no occupied slot go straight to the status; otherwise a
// tick walks all MAX_SLOTS slots, one per cycle unless a fire request waits for
// the result register, and an unsubscribe stops at its match.
// Throughput: one request at a time, taken once the status is out; a stalled
// response side holds it back. Reset: asynchronous, clears table, tick, enable.
// ----------------------------------------------------------------------------
// periodic_task_dispatcher: cooperative periodic task scheduler
// Slot records live in a RAM with registered read; valid bits, tick counter and enable
// flag in flip-flops. Ticks fire due slots in slot order, then a status.
// ----------------------------------------------------------------------------
`default_nettype none

module periodic_task_dispatcher #(
  parameter int unsigned MAX_SLOTS = 8
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  ptd_req_if.sink    req_i,
  ptd_rsp_if.source  rsp_o
);

  localparam int unsigned IdxW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(MAX_SLOTS - 1);

  // Control state
  ptd_pkg::state_e                  state_q, state_d;
  ptd_pkg::cmd_e                    op_q, op_d;
  ptd_pkg::status_e                 status_q, status_d;
  logic [IdxW-1:0]                  idx_q, idx_d;
  logic [ptd_pkg::PeriodW-1:0]      tick_q, tick_d;
  logic                             en_q, en_d;
  logic [MAX_SLOTS-1:0]             valid_q, valid_d;
  logic                             out_valid_q;

  // Request payload held for the scan
  logic [ptd_pkg::TaskW-1:0]        id_q;
  logic [ptd_pkg::PeriodW-1:0]      per_q;

  // Result register
  logic                             out_kind_q, out_kind_d;
  logic [ptd_pkg::SlotW-1:0]        out_slot_q, out_slot_d;
  logic [ptd_pkg::TaskW-1:0]        out_task_q, out_task_d;
  logic [ptd_pkg::StatusW-1:0]      out_status_q, out_status_d;
  logic                             out_last_q, out_last_d;
  logic                             load_out;
  logic                             out_free;

  // Memory port signals
  logic                             ram_we, ram_re;
  logic [IdxW-1:0]                  ram_waddr, ram_raddr;
  ptd_pkg::slot_entry_t             ram_wdata, ram_rdata;

  // Request decode
  ptd_pkg::cmd_e                    req_cmd;
  logic                             req_take;
  logic                             any_valid, all_valid;
  logic [IdxW-1:0]                  free_idx;
  logic                             fire_hit, unsub_hit;

  ptd_ram #(
    .Width (ptd_pkg::EntryW),
    .Depth (MAX_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign req_cmd   = ptd_pkg::cmd_e'(req_i.command);
  assign req_i.ready = (state_q == ptd_pkg::S_IDLE);
  assign req_take  = req_i.valid && (state_q == ptd_pkg::S_IDLE);
  assign any_valid = |valid_q;
  assign all_valid = &valid_q;
  assign out_free  = !out_valid_q || rsp_o.ready;

  // Find the lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = MAX_SLOTS - 1; i >= 0; i--) begin
      if (!valid_q[i]) begin
        free_idx = IdxW'(i);
      end
    end
  end

  // Slot checks on the record read out for idx_q
  assign fire_hit  = valid_q[idx_q] && ((tick_q - ram_rdata.stamp) == ram_rdata.period);
  assign unsub_hit = valid_q[idx_q] && (ram_rdata.task_id == id_q) &&
                     (ram_rdata.period == per_q);

  // Controller
  always_comb begin
    state_d      = state_q;
    op_d         = op_q;
    status_d     = status_q;
    idx_d        = idx_q;
    tick_d       = tick_q;
    en_d         = en_q;
    valid_d      = valid_q;
    ram_we       = 1'b0;
    ram_waddr    = idx_q;
    ram_wdata    = '{task_id: ram_rdata.task_id, period: ram_rdata.period, stamp: tick_q};
    ram_re       = 1'b0;
    ram_raddr    = idx_q;
    load_out     = 1'b0;
    out_kind_d   = ptd_pkg::KIND_STATUS;
    out_slot_d   = '0;
    out_task_d   = '0;
    out_status_d = status_q;
    out_last_d   = 1'b1;

    unique case (state_q)
      ptd_pkg::S_IDLE: begin
        if (req_take) begin
          op_d     = req_cmd;
          idx_d    = '0;
          state_d  = ptd_pkg::S_STATUS;
          status_d = ptd_pkg::STS_SUCCESS;
          unique case (req_cmd)
            ptd_pkg::CMD_TICK: begin
              if (!en_q) begin
                status_d = ptd_pkg::STS_NO_INIT;
              end else begin
                tick_d = tick_q + 1'b1;
                if (!any_valid) begin
                  status_d = ptd_pkg::STS_NO_TASKS;
                end else begin
                  ram_re    = 1'b1;
                  ram_raddr = '0;
                  state_d   = ptd_pkg::S_SCAN;
                end
              end
            end
            ptd_pkg::CMD_SUBSCRIBE: begin
              if ((req_i.period == '0) || all_valid) begin
                status_d = ptd_pkg::STS_FAIL;
              end else begin
                ram_we            = 1'b1;
                ram_waddr         = free_idx;
                ram_wdata         = '{task_id: req_i.task_id, period: req_i.period,
                                      stamp: tick_q};
                valid_d[free_idx] = 1'b1;
              end
            end
            ptd_pkg::CMD_UNSUBSCRIBE: begin
              if (!en_q) begin
                status_d = ptd_pkg::STS_NO_INIT;
              end else if (!any_valid) begin
                status_d = ptd_pkg::STS_NO_TASKS;
              end else begin
                // Fail unless a matching slot turns up
                status_d  = ptd_pkg::STS_FAIL;
                ram_re    = 1'b1;
                ram_raddr = '0;
                state_d   = ptd_pkg::S_SCAN;
              end
            end
            ptd_pkg::CMD_INIT: begin
              valid_d = '0;
              tick_d  = '0;
              en_d    = 1'b1;
            end
            ptd_pkg::CMD_DESTROY: begin
              valid_d = '0;
              en_d    = 1'b0;
            end
            default: begin
              status_d = ptd_pkg::STS_FAIL;
            end
          endcase
        end
      end

      ptd_pkg::S_SCAN: begin
        if (op_q == ptd_pkg::CMD_UNSUBSCRIBE && unsub_hit) begin
          // Drop the matching slot and stop
          valid_d[idx_q] = 1'b0;
          status_d       = ptd_pkg::STS_SUCCESS;
          state_d        = ptd_pkg::S_STATUS;
        end else if (op_q == ptd_pkg::CMD_TICK && fire_hit && !out_free) begin
          // Hold: the fire request waits for the result register
          state_d = ptd_pkg::S_SCAN;
        end else begin
          if (op_q == ptd_pkg::CMD_TICK && fire_hit) begin
            // Emit fire request and restamp the slot
            load_out     = 1'b1;
            out_kind_d   = ptd_pkg::KIND_FIRE;
            out_slot_d   = ptd_pkg::SlotW'(idx_q);
            out_task_d   = ram_rdata.task_id;
            out_status_d = ptd_pkg::STS_SUCCESS;
            out_last_d   = 1'b0;
            ram_we       = 1'b1;
          end
          // Advance to the next slot
          if (idx_q == LastIdx) begin
            state_d = ptd_pkg::S_STATUS;
          end else begin
            idx_d     = idx_q + 1'b1;
            ram_re    = 1'b1;
            ram_raddr = idx_q + 1'b1;
          end
        end
      end

      ptd_pkg::S_STATUS: begin
        if (out_free) begin
          load_out = 1'b1;
          state_d  = ptd_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = ptd_pkg::S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ptd_pkg::S_IDLE;
      op_q        <= ptd_pkg::CMD_TICK;
      status_q    <= ptd_pkg::STS_SUCCESS;
      idx_q       <= '0;
      tick_q      <= '0;
      en_q        <= 1'b0;
      valid_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      status_q <= status_d;
      idx_q    <= idx_d;
      tick_q   <= tick_d;
      en_q     <= en_d;
      valid_q  <= valid_d;
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (req_take) begin
      id_q  <= req_i.task_id;
      per_q <= req_i.period;
    end
    if (load_out) begin
      out_kind_q   <= out_kind_d;
      out_slot_q   <= out_slot_d;
      out_task_q   <= out_task_d;
      out_status_q <= out_status_d;
      out_last_q   <= out_last_d;
    end
  end

  assign rsp_o.valid      = out_valid_q;
  assign rsp_o.kind       = out_kind_q;
  assign rsp_o.slot       = out_slot_q;
  assign rsp_o.fired_task = out_task_q;
  assign rsp_o.status     = out_status_q;
  assign rsp_o.last       = out_last_q;

endmodule

`default_nettype wire

// ===== design/ptd_ram.sv =====
// ----------------------------------------------------------------------------
// ptd_ram: generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module ptd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 8
) (
  input  wire logic                                         clk_i,
  input  wire logic                                         we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                             wdata_i,
  input  wire logic                                         re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output      logic [Width-1:0]                             rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire
